>>> hw/rtl/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types and constants for the grid to graph edge emitter.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int CFG_W       = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int VERTEX_W    = 12;
  localparam int COORD_W     = 6;

  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS    = 1'd1;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_EDGE   = 1'b1;

  typedef struct packed {
    logic cell_free;
    logic grid_start;
  } cell_t;

  typedef struct packed {
    logic                record_kind;
    logic [VERTEX_W-1:0] vertex_number;
    logic [VERTEX_W-1:0] neighbour_number;
    logic [COORD_W-1:0]  cell_row;
    logic [COORD_W-1:0]  cell_column;
    logic                last_record;
  } record_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vtx;
    logic [VERTEX_W-1:0] left_vtx;
    logic [VERTEX_W-1:0] up_vtx;
    logic                has_left;
    logic                has_up;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
  } job_t;

  typedef enum logic [1:0] {
    REC_VERTEX,
    REC_LEFT,
    REC_UP
  } rec_t;

endpackage

>>> hw/rtl/gtg_ram.sv
// ----------------------------------------------------------------------------
// gtg_ram
// Single-port RAM, read-first, with registered read data.
// ----------------------------------------------------------------------------
module gtg_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/gtg_front.sv
// ----------------------------------------------------------------------------
// gtg_front
// Configuration, cell counters and line store access; builds one job per
// free cell from the counters and the entry of the row above.
// ----------------------------------------------------------------------------
module gtg_front #(
  parameter int MAX_COLUMNS = gtg_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gtg_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gtg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gtg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                cell_valid,
  output logic                                cell_stall,
  input  gtg_pkg::cell_t                      grid_cell,
  input  logic                                job_ready,
  output logic                                job_valid,
  output gtg_pkg::job_t                       job
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int VW    = gtg_pkg::VERTEX_W;
  localparam int CMP_W = (gtg_pkg::CFG_W > 11) ? gtg_pkg::CFG_W : 11;
  localparam logic [COL_W:0] MAX_COLS_C = (COL_W+1)'(MAX_COLUMNS);
  localparam logic [ROW_W:0] MAX_ROWS_C = (ROW_W+1)'(MAX_ROWS);

  logic [gtg_pkg::CFG_W-1:0] grid_columns;
  logic [gtg_pkg::CFG_W-1:0] grid_rows;
  logic [COL_W:0]            cols_eff;
  logic [ROW_W:0]            rows_eff;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [VW-1:0]    next_vertex;
  logic             left_free;
  logic [VW-1:0]    left_vertex;

  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [VW-1:0]    vtx_cur;
  logic             left_cur;
  logic [COL_W-1:0] column_count_next;
  logic [ROW_W-1:0] row_count_next;
  logic [VW-1:0]    next_vertex_next;
  logic             left_free_next;

  logic             accept;
  logic             s1_move;
  logic             s1_valid;
  logic             s1_fresh;
  logic             s1_free;
  logic             s1_has_left;
  logic             s1_row_nz;
  logic [VW-1:0]    s1_vtx;
  logic [VW-1:0]    s1_left_vtx;
  logic [gtg_pkg::COORD_W-1:0] s1_row;
  logic [gtg_pkg::COORD_W-1:0] s1_col;

  logic [VW:0]      ram_rdata;
  logic [VW:0]      hold;
  logic [VW:0]      up_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= gtg_pkg::CFG_RESET;
      grid_rows    <= gtg_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gtg_pkg::CFG_GRID_COLUMNS: grid_columns <= cfg_data;
        gtg_pkg::CFG_GRID_ROWS:    grid_rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_columns == '0) begin
      cols_eff = (COL_W+1)'(1);
    end else if (CMP_W'(grid_columns) > CMP_W'(MAX_COLUMNS)) begin
      cols_eff = MAX_COLS_C;
    end else begin
      cols_eff = (COL_W+1)'(grid_columns);
    end
    if (grid_rows == '0) begin
      rows_eff = (ROW_W+1)'(1);
    end else if (CMP_W'(grid_rows) > CMP_W'(MAX_ROWS)) begin
      rows_eff = MAX_ROWS_C;
    end else begin
      rows_eff = (ROW_W+1)'(grid_rows);
    end
  end

  assign s1_move    = s1_valid && (!s1_free || job_ready);
  assign cell_stall = s1_valid && !s1_move;
  assign accept     = cell_valid && !cell_stall;

  always_comb begin
    col_cur  = grid_cell.grid_start ? '0 : column_count;
    row_cur  = grid_cell.grid_start ? '0 : row_count;
    vtx_cur  = grid_cell.grid_start ? '0 : next_vertex;
    left_cur = grid_cell.grid_start ? 1'b0 : left_free;

    next_vertex_next = grid_cell.cell_free ? vtx_cur + VW'(1) : vtx_cur;
    left_free_next   = grid_cell.cell_free;
    row_count_next   = row_cur;
    column_count_next = col_cur + COL_W'(1);
    if (({1'b0, col_cur} + (COL_W+1)'(1)) >= cols_eff) begin
      column_count_next = '0;
      left_free_next    = 1'b0;
      if (({1'b0, row_cur} + (ROW_W+1)'(1)) >= rows_eff) begin
        row_count_next   = '0;
        next_vertex_next = '0;
      end else begin
        row_count_next = row_cur + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      next_vertex  <= '0;
      left_free    <= 1'b0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      next_vertex  <= next_vertex_next;
      left_free    <= left_free_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && grid_cell.cell_free) begin
      left_vertex <= vtx_cur;
    end
  end

  // read the row above and write this cell back in the same cycle
  gtg_ram #(
    .WIDTH(VW + 1),
    .DEPTH(MAX_COLUMNS)
  ) u_line (
    .clk  (clk),
    .we   (accept),
    .addr (col_cur),
    .wdata({grid_cell.cell_free, vtx_cur}),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fresh <= 1'b0;
    end else begin
      s1_fresh <= accept;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_free     <= grid_cell.cell_free;
      s1_has_left <= left_cur && (col_cur != '0);
      s1_row_nz   <= row_cur != '0;
      s1_vtx      <= vtx_cur;
      s1_left_vtx <= left_vertex;
      s1_row      <= gtg_pkg::COORD_W'(row_cur);
      s1_col      <= gtg_pkg::COORD_W'(col_cur);
    end
    if (s1_fresh) begin
      hold <= ram_rdata;
    end
  end

  assign up_data   = s1_fresh ? ram_rdata : hold;
  assign job_valid = s1_valid && s1_free;

  always_comb begin
    job.vtx      = s1_vtx;
    job.left_vtx = s1_left_vtx;
    job.up_vtx   = up_data[VW-1:0];
    job.has_left = s1_has_left;
    job.has_up   = s1_row_nz && up_data[VW];
    job.row      = s1_row;
    job.col      = s1_col;
  end

endmodule

>>> hw/rtl/gtg_emit.sv
// ----------------------------------------------------------------------------
// gtg_emit
// Holds one job and sends its vertex record and edge records, one per cycle while record_stall is low.
// ----------------------------------------------------------------------------
module gtg_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  gtg_pkg::job_t    job,
  output logic             job_ready,
  output logic             record_valid,
  input  logic             record_stall,
  output gtg_pkg::record_t record
);

  gtg_pkg::job_t job_q;
  gtg_pkg::rec_t rec_state;
  gtg_pkg::rec_t rec_state_next;
  logic          busy;
  logic          busy_next;
  logic          xfer;
  logic          load;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_state <= gtg_pkg::REC_VERTEX;
      busy      <= 1'b0;
    end else begin
      rec_state <= rec_state_next;
      busy      <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_q <= job;
    end
  end

  always_comb begin
    record.vertex_number = job_q.vtx;
    record.cell_row      = job_q.row;
    record.cell_column   = job_q.col;
    unique case (rec_state)
      gtg_pkg::REC_VERTEX: begin
        record.record_kind      = gtg_pkg::KIND_VERTEX;
        record.neighbour_number = '0;
        record.last_record      = !job_q.has_left && !job_q.has_up;
      end
      gtg_pkg::REC_LEFT: begin
        record.record_kind      = gtg_pkg::KIND_EDGE;
        record.neighbour_number = job_q.left_vtx;
        record.last_record      = !job_q.has_up;
      end
      gtg_pkg::REC_UP: begin
        record.record_kind      = gtg_pkg::KIND_EDGE;
        record.neighbour_number = job_q.up_vtx;
        record.last_record      = 1'b1;
      end
      default: begin
        record.record_kind      = gtg_pkg::KIND_EDGE;
        record.neighbour_number = job_q.up_vtx;
        record.last_record      = 1'b1;
      end
    endcase

    record_valid = busy;
    xfer         = busy && !record_stall;
    job_ready    = !busy || (xfer && record.last_record);
    load         = job_valid && job_ready;

    busy_next      = busy;
    rec_state_next = rec_state;
    if (load) begin
      busy_next      = 1'b1;
      rec_state_next = gtg_pkg::REC_VERTEX;
    end else if (xfer && record.last_record) begin
      busy_next = 1'b0;
    end else if (xfer) begin
      unique case (rec_state)
        gtg_pkg::REC_VERTEX:
          rec_state_next = job_q.has_left ? gtg_pkg::REC_LEFT : gtg_pkg::REC_UP;
        gtg_pkg::REC_LEFT: rec_state_next = gtg_pkg::REC_UP;
        default:           rec_state_next = gtg_pkg::REC_UP;
      endcase
    end
  end

endmodule

>>> hw/rtl/grid_to_graph_edge_emitter.sv
// ----------------------------------------------------------------------------
// grid_to_graph_edge_emitter
// Occupancy grid to 4-connected graph: vertex and edge records per cell.
// ----------------------------------------------------------------------------
// Cells enter one per transfer in row-major order. A free cell causes a
// vertex record, then an edge to the left and one upward where those cells
// are free: one to three records, all through the single record port. A
// wall cell causes no record. The line store is one single-port RAM of
// MAX_COLUMNS entries, read and written at the same column in the cycle a
// cell is taken; a cell passes the stage-one buffer and the job register of
// the record stage before its first record leaves. The one-cell buffer ahead
// of the record stage lets the cell port go on taking cells while records of
// the previous cell are still going out, until a free cell waits in it.
// ----------------------------------------------------------------------------
module grid_to_graph_edge_emitter #(
  parameter int MAX_COLUMNS = gtg_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = gtg_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [gtg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gtg_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            cell_valid,
  output logic                            cell_stall,
  input  gtg_pkg::cell_t                  grid_cell,
  output logic                            record_valid,
  input  logic                            record_stall,
  output gtg_pkg::record_t                record
);

  logic          job_valid;
  logic          job_ready;
  gtg_pkg::job_t job;

  gtg_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .grid_cell (grid_cell),
    .job_ready (job_ready),
    .job_valid (job_valid),
    .job       (job)
  );

  gtg_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job),
    .job_ready   (job_ready),
    .record_valid(record_valid),
    .record_stall(record_stall),
    .record      (record)
  );

endmodule

>>> bench/grid_to_graph_edge_emitter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_to_graph_edge_emitter_tb
// Self-checking bench for the occupancy grid to graph record emitter.
// ----------------------------------------------------------------------------
// Cells go in as bursts with random gaps while the record side stalls on a
// pattern of its own. A scoreboard keeps its own line store, counters and
// register copies, predicts the vertex and edge records of every cell taken
// and checks each record field by field. A directed opening covers reset
// sizes, a 3 x 3 grid with walls, row and grid wrap and a restart mid-row,
// and out-of-range sizes. Random phases follow at several grid sizes.
// ----------------------------------------------------------------------------

class graph_scoreboard;
  localparam int LINE_DEPTH = gtg_pkg::MAX_COLUMNS_DEF;

  int unsigned       cols_in_use;
  int unsigned       rows_in_use;
  bit                above_free [LINE_DEPTH];
  logic [11:0]       above_vertex [LINE_DEPTH];
  bit                left_free;
  int unsigned       row_count;
  int unsigned       column_count;
  logic [11:0]       next_vertex;
  gtg_pkg::record_t  pending [$];
  int                errors;
  int                cells_taken;
  int                vertices_seen;
  int                edges_seen;

  function new();
    cols_in_use = gtg_pkg::CFG_RESET;
    rows_in_use = gtg_pkg::CFG_RESET;
    foreach (above_free[i]) begin
      above_free[i]   = 1'b0;
      above_vertex[i] = '0;
    end
    restart_grid();
    errors        = 0;
    cells_taken   = 0;
    vertices_seen = 0;
    edges_seen    = 0;
  endfunction

  function void restart_grid();
    row_count    = 0;
    column_count = 0;
    next_vertex  = '0;
    left_free    = 1'b0;
  endfunction

  function int unsigned clamp_size(logic [gtg_pkg::CFG_W-1:0] value, int unsigned limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  function void write_reg(logic [gtg_pkg::CFG_INDEX_W-1:0] index,
                          logic [gtg_pkg::CFG_W-1:0] value);
    if (index == gtg_pkg::CFG_GRID_COLUMNS)
      cols_in_use = clamp_size(value, gtg_pkg::MAX_COLUMNS_DEF);
    else if (index == gtg_pkg::CFG_GRID_ROWS)
      rows_in_use = clamp_size(value, gtg_pkg::MAX_ROWS_DEF);
  endfunction

  function void push_record(logic kind, logic [11:0] vtx, logic [11:0] nbr, logic last);
    gtg_pkg::record_t r;
    r.record_kind      = kind;
    r.vertex_number    = vtx;
    r.neighbour_number = nbr;
    r.cell_row         = row_count[5:0];
    r.cell_column      = column_count[5:0];
    r.last_record      = last;
    pending.push_back(r);
  endfunction

  function void note_cell(gtg_pkg::cell_t c);
    int unsigned col_idx;
    bit          has_left;
    bit          has_up;
    logic [11:0] vtx;
    cells_taken++;
    if (c.grid_start) restart_grid();
    col_idx = column_count % LINE_DEPTH;
    if (c.cell_free) begin
      vtx      = next_vertex;
      has_left = left_free && column_count > 0;
      has_up   = row_count > 0 && above_free[col_idx];
      push_record(gtg_pkg::KIND_VERTEX, vtx, '0, !has_left && !has_up);
      if (has_left)
        push_record(gtg_pkg::KIND_EDGE, vtx, above_vertex[(col_idx + LINE_DEPTH - 1) % LINE_DEPTH],
                    !has_up);
      if (has_up)
        push_record(gtg_pkg::KIND_EDGE, vtx, above_vertex[col_idx], 1'b1);
      above_free[col_idx]   = 1'b1;
      above_vertex[col_idx] = vtx;
      left_free             = 1'b1;
      next_vertex           = next_vertex + 1'b1;
    end else begin
      above_free[col_idx] = 1'b0;
      left_free           = 1'b0;
    end
    if (column_count + 1 >= cols_in_use) begin
      column_count = 0;
      left_free    = 1'b0;
      if (row_count + 1 >= rows_in_use) restart_grid();
      else row_count++;
    end else begin
      column_count++;
    end
  endfunction

  function void compare_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function void check_record(gtg_pkg::record_t got);
    gtg_pkg::record_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: unexpected record, expected none, got %h", $time, got);
      return;
    end
    want = pending.pop_front();
    if (got.record_kind === gtg_pkg::KIND_EDGE) edges_seen++;
    else vertices_seen++;
    compare_field("record_kind", want.record_kind, got.record_kind);
    compare_field("vertex_number", want.vertex_number, got.vertex_number);
    compare_field("neighbour_number", want.neighbour_number, got.neighbour_number);
    compare_field("cell_row", want.cell_row, got.cell_row);
    compare_field("cell_column", want.cell_column, got.cell_column);
    compare_field("last_record", want.last_record, got.last_record);
  endfunction
endclass

module grid_to_graph_edge_emitter_tb;

  localparam int CYCLE_LIMIT = 300000;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [gtg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [gtg_pkg::CFG_W-1:0]       cfg_data = '0;
  logic                            cell_valid = 1'b0;
  logic                            cell_stall;
  gtg_pkg::cell_t                  grid_cell = '0;
  logic                            record_valid;
  logic                            record_stall = 1'b0;
  gtg_pkg::record_t                record;

  graph_scoreboard sb = new();
  int              cycle_count = 0;
  int              burst_left = 0;
  int              stall_left = 0;
  int              stall_pct = 0;
  int              settings_run = 0;

  grid_to_graph_edge_emitter DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cell_valid   (cell_valid),
    .cell_stall   (cell_stall),
    .grid_cell    (grid_cell),
    .record_valid (record_valid),
    .record_stall (record_stall),
    .record       (record)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d records outstanding", cycle_count,
               sb.pending.size());
      $display("grid_to_graph_edge_emitter_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cell_valid && !cell_stall) sb.note_cell(grid_cell);
      if (record_valid && !record_stall) sb.check_record(record);
    end
  end

  // hold each stall level for a stretch, including stretches with none
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(10, 60);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end else begin
      stall_left--;
    end
    record_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  task automatic send_cell(input logic free, input logic start);
    gtg_pkg::cell_t c;
    int             gap;
    c.cell_free  = free;
    c.grid_start = start;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cell_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cell_valid <= 1'b1;
    grid_cell  <= c;
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    cell_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_grid(input logic [gtg_pkg::CFG_W-1:0] cols,
                          input logic [gtg_pkg::CFG_W-1:0] rows);
    cfg_write <= 1'b1;
    cfg_index <= gtg_pkg::CFG_GRID_COLUMNS;
    cfg_data  <= cols;
    sb.write_reg(gtg_pkg::CFG_GRID_COLUMNS, cols);
    @(negedge clk);
    cfg_index <= gtg_pkg::CFG_GRID_ROWS;
    cfg_data  <= rows;
    sb.write_reg(gtg_pkg::CFG_GRID_ROWS, rows);
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  initial begin
    int phase_cols [6] = '{127, 6, 1, 64, 9, 2};
    int phase_rows [6] = '{2, 5, 127, 0, 64, 3};
    int phase_len  [6] = '{118, 70, 60, 70, 80, 50};
    int phase_free [6] = '{80, 60, 70, 85, 50, 75};

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset sizes, start of row 0
    settings_run = 1;
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    drain();

    // 3 x 3 grid with walls, wrap into a new grid, restart mid-row
    set_grid(7'd3, 7'd3);
    send_cell(1'b1, 1'b1);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b0);
    send_cell(1'b1, 1'b1);
    send_cell(1'b1, 1'b0);
    drain();

    // zero sizes act as a single cell grid
    set_grid(7'd0, 7'd0);
    send_cell(1'b1, 1'b1);
    send_cell(1'b1, 1'b0);
    send_cell(1'b0, 1'b0);
    send_cell(1'b1, 1'b1);
    send_cell(1'b1, 1'b0);
    drain();

    foreach (phase_len[p]) begin
      set_grid(gtg_pkg::CFG_W'(phase_cols[p]), gtg_pkg::CFG_W'(phase_rows[p]));
      for (int i = 0; i < phase_len[p]; i++)
        send_cell($urandom_range(99) < phase_free[p], (i == 0) || ($urandom_range(99) < 3));
      drain();
    end

    repeat (20) @(negedge clk);
    $display("Sent %0d cells over %0d grid settings, sizes 1 to 64 and out of range.",
             sb.cells_taken, settings_run);
    $display("Checked %0d vertex records and %0d edge records.", sb.vertices_seen,
             sb.edges_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("grid_to_graph_edge_emitter_tb OK");
    end else begin
      $display("grid_to_graph_edge_emitter_tb NOT OK");
    end
    $finish;
  end
endmodule
